>>> rtl/zero_crossing_tracked_sawtooth_defines.svh
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: assertion macros
// Shared check macros; they expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_TRACKED_SAWTOOTH_DEFINES_SVH
`define ZERO_CROSSING_TRACKED_SAWTOOTH_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every edge outside reset
`define ZCTS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("zcts check failed");
// Consequent holds in the same cycle as the antecedent
`define ZCTS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zcts check failed");
// Consequent holds in the cycle after the antecedent
`define ZCTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zcts check failed");
`else
`define ZCTS_ASSERT_ALWAYS(lbl, cond)
`define ZCTS_ASSERT_IMPLIES(lbl, ante, cons)
`define ZCTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/zcts_pkg.sv
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: package
// Word types, register indexes and reset constants shared by the block.
// ----------------------------------------------------------------------------
package zcts_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int SAW_W     = 12;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 1'b1;

    // Register reset values
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 16'd10;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 16'd4800;

    // Saturation point of the crossing counter
    localparam logic [PERIOD_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
    } in_word_t;

    typedef struct packed {
        logic signed [SAW_W-1:0]    saw_a;
        logic signed [SAW_W-1:0]    saw_b;
        logic        [PERIOD_W-1:0] period_a;
        logic        [PERIOD_W-1:0] period_b;
    } out_word_t;

    // Period window handed to every lane
    typedef struct packed {
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
    } cfg_t;

    // What one lane reports for the current word
    typedef struct packed {
        logic signed [SAW_W-1:0] saw;
        logic [PERIOD_W-1:0]     period;
    } lane_res_t;

endpackage

>>> rtl/zcts_if.sv
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: channel interfaces
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface zcts_in_if;
    logic               valid;
    logic               ready;
    zcts_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface zcts_out_if;
    logic                valid;
    logic                ready;
    zcts_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/zcts_div.sv
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: serial divider
// Restoring divider for 2^(QW-1) / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zcts_div #(
    parameter int QW = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [zcts_pkg::PERIOD_W-1:0] divisor,
    output logic                          done,
    output logic [QW-1:0]                 quotient
);

    localparam int DW = zcts_pkg::PERIOD_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg,  busy_next;
    logic          done_reg,  done_next;
    logic          first_reg, first_next;
    logic [CW-1:0] step_reg,  step_next;
    logic [DW-1:0] div_reg,   div_next;
    logic [DW-1:0] rem_reg,   rem_next;
    logic [QW-1:0] quot_reg,  quot_next;

    logic [DW:0]   trial;
    logic          fits;

    // Shift in the next dividend bit: a one first, zeros after
    assign trial = {rem_reg, first_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        first_next = first_reg;
        step_next  = step_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            step_next  = CW'(QW);
            div_next   = divisor;
            rem_next   = '0;
            quot_next  = '0;
        end
        else if (busy_reg)
        begin
            first_next = 1'b0;
            rem_next   = fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
            quot_next  = {quot_reg[QW-2:0], fits};
            step_next  = step_reg - 1'b1;
            if (step_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        step_reg  <= step_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/zcts_lane.sv
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: channel lane
// Crossing detector, period counter, increment divider and phase oscillator
// for one audio channel.
// ----------------------------------------------------------------------------
module zcts_lane #(
    parameter int PHASE_BITS   = 30,
    parameter int RESET_PERIOD = 48000
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [zcts_pkg::SAMPLE_W-1:0] sample,
    input  zcts_pkg::cfg_t                       cfg,
    output logic                                 done,
    output zcts_pkg::lane_res_t                  res
);

    localparam int PW = zcts_pkg::PERIOD_W;
    localparam int QW = PHASE_BITS + 1;

    logic                  prev_reg,  prev_next;
    logic [PW-1:0]         count_reg, count_next;
    logic [PW-1:0]         meas_reg,  meas_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  done_reg;
    logic [zcts_pkg::SAW_W-1:0] saw_reg, saw_next;

    logic          nonneg;
    logic          rising;
    logic [PW-1:0] count_base;
    logic [PW-1:0] divisor;
    logic          div_done;
    logic [QW-1:0] quotient;
    logic [QW-1:0] phase_sum;
    logic [10:0]   phase_top;

    // Detect the rising crossing and take the count as period when in window
    assign nonneg = ~sample[zcts_pkg::SAMPLE_W-1];
    assign rising = nonneg & ~prev_reg;

    always_comb
    begin
        meas_next  = meas_reg;
        count_base = count_reg;
        if (rising)
        begin
            if ((count_reg > cfg.min_period) && (count_reg < cfg.max_period))
            begin
                meas_next = count_reg;
            end
            count_base = '0;
        end
        count_next = (count_base != zcts_pkg::COUNT_MAX) ? count_base + 1'b1 : count_base;
        prev_next  = nonneg;
        divisor    = (meas_next == '0) ? PW'(1) : meas_next;
    end

    zcts_div #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Advance the phase; the sum stays below twice the full scale, so drop the carry
    assign phase_sum  = QW'(phase_reg) + quotient;
    assign phase_next = phase_sum[PHASE_BITS-1:0];
    assign phase_top  = phase_next[PHASE_BITS-1 -: 11];
    assign saw_next   = {~phase_top[10], phase_top[9:0], 1'b0};

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            count_reg <= '0;
            meas_reg  <= PW'(RESET_PERIOD);
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= div_done;
            if (start)
            begin
                prev_reg  <= prev_next;
                count_reg <= count_next;
                meas_reg  <= meas_next;
            end
            if (div_done)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    // Hold the sawtooth code until the next word
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            saw_reg <= saw_next;
        end
    end

    assign done       = done_reg;
    assign res.saw    = saw_reg;
    assign res.period = meas_reg;

endmodule

>>> rtl/zcts_merge.sv
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: lane merge
// Gathers both lane results into one output word and holds it until taken.
// ----------------------------------------------------------------------------
module zcts_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pending,
    input  zcts_pkg::lane_res_t res_a,
    input  zcts_pkg::lane_res_t res_b,
    output logic                taken,
    zcts_out_if.source          results
);

    logic                valid_reg;
    zcts_pkg::out_word_t data_reg;

    // Load when the output register is empty or drains this cycle
    assign taken = pending & (~valid_reg | results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (taken)
        begin
            valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            data_reg.saw_a    <= res_a.saw;
            data_reg.saw_b    <= res_b.saw;
            data_reg.period_a <= res_a.period;
            data_reg.period_b <= res_b.period;
        end
    end

    assign results.valid = valid_reg;
    assign results.data  = data_reg;

endmodule

>>> rtl/zero_crossing_tracked_sawtooth.sv
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: top level
// Two-channel pitch tracker driving sawtooth oscillators, one lane per channel.
// ----------------------------------------------------------------------------
//  port       dir   word
//  samples    sink  sample_a, sample_b
//  results    src   saw_a, saw_b, period_a, period_b
//  wr_*       in    register write (index 0 min_period, 1 max_period)
//
//  From accept a word passes through the bit-serial increment divider and
//  the done register in each lane, then the pending register, to the
//  output register; the two lanes run in lockstep. Reset returns all channel
//  state at once, no clearing pass. A finished word waits in the output
//  register while the next sample word is accepted; a stalled result holds
//  the lanes' next hand-off, and samples.ready stays low until it moves.
// ----------------------------------------------------------------------------
`include "zero_crossing_tracked_sawtooth_defines.svh"

module zero_crossing_tracked_sawtooth #(
    parameter int RESET_PERIOD = 48000,
    parameter int PHASE_BITS   = 30
) (
    input  logic                             clk,
    input  logic                             rst_n,
    zcts_in_if.sink                          samples,
    zcts_out_if.source                       results,
    input  logic                             wr_en,
    input  logic [zcts_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [zcts_pkg::CFG_DATA_W-1:0]  wr_data
);

    zcts_pkg::cfg_t      cfg_reg;
    logic                busy_reg;
    logic                pend_reg;
    logic                accept;
    logic                taken;
    logic [1:0]          lane_done;
    zcts_pkg::lane_res_t res_a;
    zcts_pkg::lane_res_t res_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_period <= zcts_pkg::MIN_PERIOD_RST;
            cfg_reg.max_period <= zcts_pkg::MAX_PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                zcts_pkg::REG_MIN_PERIOD: cfg_reg.min_period <= wr_data;
                zcts_pkg::REG_MAX_PERIOD: cfg_reg.max_period <= wr_data;
                default:                  ;
            endcase
        end
    end

    // Take a word whenever the lanes are free
    assign samples.ready = ~busy_reg;
    assign accept        = samples.valid & ~busy_reg;

    // Track the word from accept until the merge takes its result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (taken)
            begin
                busy_reg <= 1'b0;
            end
            if (taken)
            begin
                pend_reg <= 1'b0;
            end
            else if (lane_done[0])
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    zcts_lane #(
        .PHASE_BITS   (PHASE_BITS),
        .RESET_PERIOD (RESET_PERIOD)
    ) u_lane_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (samples.data.sample_a),
        .cfg    (cfg_reg),
        .done   (lane_done[0]),
        .res    (res_a)
    );

    zcts_lane #(
        .PHASE_BITS   (PHASE_BITS),
        .RESET_PERIOD (RESET_PERIOD)
    ) u_lane_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (samples.data.sample_b),
        .cfg    (cfg_reg),
        .done   (lane_done[1]),
        .res    (res_b)
    );

    zcts_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .pending (pend_reg),
        .res_a   (res_a),
        .res_b   (res_b),
        .taken   (taken),
        .results (results)
    );

    // Checks
    `ZCTS_ASSERT_ALWAYS(a_lanes_lockstep, lane_done[0] == lane_done[1])
    `ZCTS_ASSERT_IMPLIES(a_done_while_busy, lane_done[0], busy_reg && !pend_reg)
    `ZCTS_ASSERT_IMPLIES(a_pend_while_busy, pend_reg, busy_reg)
    `ZCTS_ASSERT_NEXT(a_taken_shows, taken, results.valid)

endmodule

>>> sim/zero_crossing_tracked_sawtooth_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing tracked sawtooth: self-checking testbench
// Sends sample words through the valid/ready input channel and checks each
// result word field by field against a predictor kept in the bench. The run
// covers a directed table, periodic waveforms with noise under several period
// windows, random idling on both channels, and a stretch of silence with no
// rising crossing on either channel.
// ----------------------------------------------------------------------------
module zero_crossing_tracked_sawtooth_test;

    localparam int PHASE_BITS   = 30;
    localparam int RESET_PERIOD = 48000;
    localparam int SILENCE_LEN  = 100;
    localparam logic [PHASE_BITS:0] PHASE_FULL = {1'b1, {PHASE_BITS{1'b0}}};

    // One row of the directed table; want holds a typed-in result when known
    typedef struct packed {
        logic [zcts_pkg::SAMPLE_W-1:0] a;
        logic [zcts_pkg::SAMPLE_W-1:0] b;
        logic                          typed;
        zcts_pkg::out_word_t           want;
    } script_row_t;

    localparam int SCRIPT_LEN = 20;
    // After reset a non-negative sample crosses but count 0 is rejected; the
    // phase takes one step of 2^30/48000, so both saws sit at the bottom.
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{12'h000, 12'h800, 1'b1, '{12'h800, 12'h800, 16'd48000, 16'd48000}},
        '{12'hFFF, 12'h7FF, 1'b0, '0},
        '{12'h7FF, 12'hFFF, 1'b0, '0},
        '{12'h800, 12'h000, 1'b0, '0},
        '{12'hC00, 12'hFFF, 1'b0, '0},
        '{12'hFFF, 12'h001, 1'b0, '0},
        '{12'h800, 12'h800, 1'b0, '0},
        '{12'hFFD, 12'h7FF, 1'b0, '0},
        '{12'h801, 12'hFFF, 1'b0, '0},
        '{12'hFFF, 12'h000, 1'b0, '0},
        '{12'hF9C, 12'hFFF, 1'b0, '0},
        '{12'hFFF, 12'h400, 1'b0, '0},
        '{12'h800, 12'hFFF, 1'b0, '0},
        '{12'hFFF, 12'h000, 1'b0, '0},
        '{12'h001, 12'h800, 1'b0, '0},
        '{12'h7FF, 12'h005, 1'b0, '0},
        '{12'hFFF, 12'hFFF, 1'b0, '0},
        '{12'h000, 12'hFFF, 1'b0, '0},
        '{12'h800, 12'h800, 1'b0, '0},
        '{12'h3FF, 12'h7FF, 1'b0, '0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic [zcts_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [zcts_pkg::CFG_DATA_W-1:0] wr_data;

    zcts_in_if  sample_ch ();
    zcts_out_if result_ch ();

    zero_crossing_tracked_sawtooth #(
        .RESET_PERIOD (RESET_PERIOD),
        .PHASE_BITS   (PHASE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .results  (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predicted tracker state, one entry per channel
    logic                            lane_was_nonneg [2];
    logic [zcts_pkg::PERIOD_W-1:0]   lane_run_len    [2];
    logic [zcts_pkg::PERIOD_W-1:0]   lane_period     [2];
    logic [PHASE_BITS-1:0]           lane_phase      [2];
    logic [zcts_pkg::PERIOD_W-1:0]   window_lo;
    logic [zcts_pkg::PERIOD_W-1:0]   window_hi;

    // Waveform generator state per channel
    int wave_len [2];
    int wave_pos [2];
    int wave_amp [2];

    zcts_pkg::out_word_t pending_words [$];
    int                  send_idle;
    int                  recv_idle;
    int                  mismatches;
    int                  sent_words;
    int                  checked_words;
    int                  window_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance one channel of the tracker by one sample; return its saw code
    function automatic logic [zcts_pkg::SAW_W-1:0] track_lane(
        int ch, logic [zcts_pkg::SAMPLE_W-1:0] smp);
        logic                          nonneg;
        logic [zcts_pkg::PERIOD_W-1:0] divisor;
        logic [PHASE_BITS:0]           step;
        logic [PHASE_BITS:0]           sum;
        nonneg = ~smp[zcts_pkg::SAMPLE_W-1];
        if (nonneg && !lane_was_nonneg[ch])
        begin
            if (lane_run_len[ch] > window_lo && lane_run_len[ch] < window_hi)
                lane_period[ch] = lane_run_len[ch];
            lane_run_len[ch] = '0;
        end
        if (lane_run_len[ch] != zcts_pkg::COUNT_MAX)
            lane_run_len[ch] = lane_run_len[ch] + 1'b1;
        lane_was_nonneg[ch] = nonneg;
        divisor = (lane_period[ch] == '0) ? 16'd1 : lane_period[ch];
        step = PHASE_FULL / divisor;
        sum = {1'b0, lane_phase[ch]} + step;
        if (sum >= PHASE_FULL)
            sum = sum - PHASE_FULL;
        lane_phase[ch] = sum[PHASE_BITS-1:0];
        // top 11 bits less 1024 flips the msb; doubling appends a zero
        return {~lane_phase[ch][PHASE_BITS-1], lane_phase[ch][PHASE_BITS-2:PHASE_BITS-11], 1'b0};
    endfunction

    function automatic zcts_pkg::out_word_t predict_word(
        logic [zcts_pkg::SAMPLE_W-1:0] a, logic [zcts_pkg::SAMPLE_W-1:0] b);
        zcts_pkg::out_word_t w;
        w.saw_a    = track_lane(0, a);
        w.saw_b    = track_lane(1, b);
        w.period_a = lane_period[0];
        w.period_b = lane_period[1];
        return w;
    endfunction

    // Pick a new waveform period, often near the edges of the window
    function automatic int pick_period();
        int r;
        int p;
        r = $urandom_range(9);
        if (r < 4)
            p = $urandom_range(40, 2);
        else if (r == 4)
            p = int'(window_lo) - 1 + $urandom_range(3);
        else if (r == 5)
            p = int'(window_hi) - 2 + $urandom_range(3);
        else if (r < 9)
            p = $urandom_range(250, 41);
        else
            p = $urandom_range(900, 251);
        if (p < 2)
            p = 2;
        if (p > 900)
            p = 900;
        return p;
    endfunction

    // Next sample of a square-ish periodic wave with random content and noise
    function automatic logic [zcts_pkg::SAMPLE_W-1:0] waveform_sample(int ch);
        int v;
        if (wave_pos[ch] >= wave_len[ch])
        begin
            wave_pos[ch] = 0;
            if ($urandom_range(3) == 0)
            begin
                wave_len[ch] = pick_period();
                wave_amp[ch] = ($urandom_range(4) == 0) ? 2047 : $urandom_range(2047);
            end
        end
        if ($urandom_range(99) < 8)
            v = $urandom_range(4095);
        else if (wave_pos[ch] < wave_len[ch] / 2)
            v = $urandom_range(wave_amp[ch]);
        else
            v = -$urandom_range(wave_amp[ch] + 1, 1);
        wave_pos[ch] = wave_pos[ch] + 1;
        return v[zcts_pkg::SAMPLE_W-1:0];
    endfunction

    // Offer one word and hold it until accepted; returns at a falling edge
    task automatic send_word(logic [zcts_pkg::SAMPLE_W-1:0] a,
                             logic [zcts_pkg::SAMPLE_W-1:0] b,
                             logic typed = 1'b0,
                             zcts_pkg::out_word_t typed_word = '0);
        logic                taken;
        zcts_pkg::out_word_t w;
        while ($urandom_range(99) < send_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= zcts_pkg::in_word_t'{a, b};
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = sample_ch.ready;
            if (taken)
            begin
                w = predict_word(a, b);
                pending_words.push_back(typed ? typed_word : w);
                sent_words++;
            end
            @(negedge clk);
        end
    endtask

    task automatic run_waveforms(int count);
        logic [zcts_pkg::SAMPLE_W-1:0] a;
        logic [zcts_pkg::SAMPLE_W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = waveform_sample(0);
            b = waveform_sample(1);
            send_word(a, b);
        end
    endtask

    // Drain outstanding results, then write both window registers
    task automatic set_window(logic [zcts_pkg::PERIOD_W-1:0] lo,
                              logic [zcts_pkg::PERIOD_W-1:0] hi);
        sample_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= zcts_pkg::REG_MIN_PERIOD;
        wr_data  <= lo;
        @(negedge clk);
        wr_index <= zcts_pkg::REG_MAX_PERIOD;
        wr_data  <= hi;
        @(negedge clk);
        wr_en    <= 1'b0;
        window_lo = lo;
        window_hi = hi;
        window_count++;
    endtask

    // Receiver: drop ready at random
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic void check_field(string fld, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        zcts_pkg::out_word_t want;
        zcts_pkg::out_word_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result word, got saw %0d/%0d period %0d/%0d",
                         $time, got.saw_a, got.saw_b, got.period_a, got.period_b);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("saw_a", want.saw_a, got.saw_a);
                check_field("saw_b", want.saw_b, got.saw_b);
                check_field("period_a", want.period_a, got.period_a);
                check_field("period_b", want.period_b, got.period_b);
                checked_words++;
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n           = 1'b0;
        wr_en           = 1'b0;
        wr_index        = zcts_pkg::REG_MIN_PERIOD;
        wr_data         = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        mismatches      = 0;
        sent_words      = 0;
        checked_words   = 0;
        window_count    = 0;
        send_idle       = 26;
        recv_idle       = 45;
        window_lo       = zcts_pkg::MIN_PERIOD_RST;
        window_hi       = zcts_pkg::MAX_PERIOD_RST;
        for (int ch = 0; ch < 2; ch++)
        begin
            lane_was_nonneg[ch] = 1'b0;
            lane_run_len[ch]    = '0;
            lane_period[ch]     = zcts_pkg::PERIOD_W'(RESET_PERIOD);
            lane_phase[ch]      = '0;
            wave_len[ch]        = 2;
            wave_pos[ch]        = 0;
            wave_amp[ch]        = 2047;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed table under the reset window
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_word(SCRIPT[i].a, SCRIPT[i].b, SCRIPT[i].typed, SCRIPT[i].want);
        run_waveforms(400);

        set_window(16'd0, 16'd65535);
        run_waveforms(400);

        // Swap idling between sender and receiver
        send_idle = 45;
        recv_idle = 26;
        set_window(16'd65535, 16'd1);
        run_waveforms(250);
        set_window(16'd20, 16'd21);
        run_waveforms(250);

        // No idling from here on
        send_idle = 0;
        recv_idle = 0;
        set_window(16'd3, 16'd60);
        run_waveforms(350);

        // Silence: one zero word, then negative samples only; the counters keep running
        set_window(16'd0, 16'd65535);
        send_word(12'h000, 12'h000);
        for (int i = 0; i < SILENCE_LEN; i++)
            send_word({1'b1, 11'($urandom)}, {1'b1, 11'($urandom)});
        run_waveforms(60);

        sample_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d sample words over %0d window settings plus reset window;",
                 sent_words, window_count);
        $display("checked %0d result words, %0d field mismatches.", checked_words, mismatches);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #300_000_000;
        $display("Timeout with %0d result words outstanding", pending_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
